/* rtl/foc_pkg.sv */
`default_nettype none
package foc_pkg;

   localparam logic [2:0] CSR_IA_OFFSET   = 3'd0;
   localparam logic [2:0] CSR_IB_OFFSET   = 3'd1;
   localparam logic [2:0] CSR_ANGLE_ZERO  = 3'd2;
   localparam logic [2:0] CSR_REVERSE_DIR = 3'd3;
   localparam logic [2:0] CSR_ID_TARGET   = 3'd4;
   localparam logic [2:0] CSR_IQ_TARGET   = 3'd5;
   localparam logic [2:0] CSR_PI_KP       = 3'd6;
   localparam logic [2:0] CSR_PI_KI_DT    = 3'd7;

   localparam logic signed [17:0] CORDIC_X0 = 18'sd19898;

   // multiply/accumulate program, one entry per product
   typedef enum logic [4:0] {
      OP_SA, OP_SB, OP_EL, OP_BE1, OP_BE2, OP_ID1, OP_ID2, OP_IQ1, OP_IQ2,
      OP_DI, OP_DP, OP_QI, OP_QP, OP_VA1, OP_VA2, OP_VB1, OP_VB2,
      OP_PA, OP_DA, OP_PB1, OP_PB2, OP_DB, OP_PC1, OP_PC2, OP_DC
   } op_type;

   typedef struct packed {
      logic        start;
      logic [10:0] k;
   } cor_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] value;
   } cor_rsp_type;

   function automatic logic [13:0] atan_step(input logic [3:0] i);
      logic [13:0] r;
      begin
         case (i)
            4'd0:  r = 14'd8192;
            4'd1:  r = 14'd4836;
            4'd2:  r = 14'd2555;
            4'd3:  r = 14'd1297;
            4'd4:  r = 14'd651;
            4'd5:  r = 14'd326;
            4'd6:  r = 14'd163;
            4'd7:  r = 14'd81;
            4'd8:  r = 14'd41;
            4'd9:  r = 14'd20;
            4'd10: r = 14'd10;
            4'd11: r = 14'd5;
            4'd12: r = 14'd3;
            4'd13: r = 14'd1;
            4'd14: r = 14'd1;
            default: r = 14'd0;
         endcase
         return r;
      end
   endfunction

endpackage
`default_nettype wire

/* rtl/foc_current_loop_unit.sv */
`default_nettype none
// channel | dir | handshake             | payload
// req     | in  | req_tvalid/req_tready | tdata: adc_a, adc_b, angle_raw
// rsp     | out | rsp_tvalid/rsp_tready | tdata: duty_a..c, id/iq_meas, el_phase
// csr     | in  | csr_we                | csr_addr, csr_wdata
// A transaction runs, from acceptance to the next ready, through 25 products
// (each a load step, 18 multiplier-bit steps and a post step),
// two CORDIC runs for sine and cosine, and an output step.
// Reset (synchronous) clears the integrators, the sequencer and the
// configuration registers to their defaults. A finished result waits in the output
// register; the output step stalls while the previous one is not taken.
module foc_current_loop_unit #(
   parameter int ROTOR_PAIRS   = 7,
   parameter int PWM_PERIOD    = 4199,
   parameter int OUT_LIMIT     = 26214,
   parameter int CURRENT_SCALE = 16
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire [39:0] req_tdata,   // adc_a[11:0], adc_b[23:12], angle_raw[35:24], zero
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [87:0] rsp_tdata,  // duty_a, duty_b, duty_c, id_meas, iq_meas,
                                   // el_phase, zero
   input  wire        csr_we,
   input  wire [2:0]  csr_addr,
   input  wire [15:0] csr_wdata
);

   localparam int MUL_BITS = 18;
   localparam logic signed [39:0] OLIM = 40'(OUT_LIMIT);
   localparam logic signed [39:0] ILIM = 40'(OUT_LIMIT) <<< 8;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_LOAD = 7'b0000010,
      ST_MUL  = 7'b0000100,
      ST_POST = 7'b0001000,
      ST_COR1 = 7'b0010000,
      ST_COR2 = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   state_type       state_ff;
   foc_pkg::op_type op_ff;
   logic [4:0]      cnt_ff;

   logic [11:0] ia_off_ff, ib_off_ff, zero_ff;
   logic        rev_ff;
   logic signed [15:0] id_tgt_ff, iq_tgt_ff;
   logic [15:0] kp_ff, ki_ff;

   logic [11:0] adc_a_ff, adc_b_ff, raw_ff;
   logic signed [15:0] ia_ff, ib_ff, id_ff, iq_ff, vd_ff, vq_ff;
   logic signed [15:0] sin_ff, cos_ff;
   logic signed [17:0] beta_ff, valpha_ff, vbeta_ff;
   logic signed [23:0] integ_d_ff, integ_q_ff;
   logic [11:0] elec_ff;
   logic [15:0] p_ff, u_ff;
   logic [12:0] duty_a_ff, duty_b_ff;

   logic signed [39:0] acc_ff, a_sh_ff, partial;
   logic signed [17:0] b_sh_ff;
   logic signed [19:0] a_sel;
   logic signed [17:0] b_sel;
   logic               acc_keep;

   logic signed [12:0] da, db;
   logic [11:0]        mech;
   logic signed [16:0] e_d, e_q;
   logic signed [39:0] rnd15, rnd12, rnd8, integ_sel, integ_sum, integ_new;
   logic signed [39:0] irnd, v_sum, u_sum;
   logic signed [15:0] v_new, s_in, c_in;
   logic [15:0]        u_new;

   logic         rsp_valid_ff;
   logic [87:0]  rsp_data_ff;

   foc_pkg::cor_req_type cor_req;
   foc_pkg::cor_rsp_type cor_rsp;

   foc_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .req   (cor_req),
      .rsp   (cor_rsp)
   );

   function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
      logic signed [15:0] r;
      begin
         if (v > 40'sd32767) begin
            r = 16'sh7fff;
         end else if (v < -40'sd32768) begin
            r = 16'sh8000;
         end else begin
            r = v[15:0];
         end
         return r;
      end
   endfunction

   assign da   = signed'({1'b0, adc_a_ff}) - signed'({1'b0, ia_off_ff});
   assign db   = signed'({1'b0, adc_b_ff}) - signed'({1'b0, ib_off_ff});
   assign mech = rev_ff ? (zero_ff - raw_ff) : (raw_ff - zero_ff);
   assign e_d  = 17'(id_tgt_ff) - 17'(id_ff);
   assign e_q  = 17'(iq_tgt_ff) - 17'(iq_ff);

   always_comb begin
      a_sel = 20'sd0;
      b_sel = 18'sd0;
      case (op_ff)
         foc_pkg::OP_SA:  begin a_sel = 20'(da); b_sel = 18'(CURRENT_SCALE); end
         foc_pkg::OP_SB:  begin a_sel = 20'(db); b_sel = 18'(CURRENT_SCALE); end
         foc_pkg::OP_EL:  begin a_sel = signed'({8'd0, mech}); b_sel = 18'(ROTOR_PAIRS); end
         foc_pkg::OP_BE1: begin a_sel = 20'(ia_ff); b_sel = 18'sd18919; end
         foc_pkg::OP_BE2: begin a_sel = 20'(ib_ff); b_sel = 18'sd37837; end
         foc_pkg::OP_ID1: begin a_sel = 20'(ia_ff); b_sel = 18'(cos_ff); end
         foc_pkg::OP_ID2: begin a_sel = 20'(beta_ff); b_sel = 18'(sin_ff); end
         foc_pkg::OP_IQ1: begin a_sel = 20'(beta_ff); b_sel = 18'(cos_ff); end
         foc_pkg::OP_IQ2: begin a_sel = -20'(ia_ff); b_sel = 18'(sin_ff); end
         foc_pkg::OP_DI:  begin a_sel = 20'(e_d); b_sel = signed'({2'b00, ki_ff}); end
         foc_pkg::OP_DP:  begin a_sel = 20'(e_d); b_sel = signed'({2'b00, kp_ff}); end
         foc_pkg::OP_QI:  begin a_sel = 20'(e_q); b_sel = signed'({2'b00, ki_ff}); end
         foc_pkg::OP_QP:  begin a_sel = 20'(e_q); b_sel = signed'({2'b00, kp_ff}); end
         foc_pkg::OP_VA1: begin a_sel = 20'(vd_ff); b_sel = 18'(cos_ff); end
         foc_pkg::OP_VA2: begin a_sel = -20'(vq_ff); b_sel = 18'(sin_ff); end
         foc_pkg::OP_VB1: begin a_sel = 20'(vd_ff); b_sel = 18'(sin_ff); end
         foc_pkg::OP_VB2: begin a_sel = 20'(vq_ff); b_sel = 18'(cos_ff); end
         foc_pkg::OP_PA:  begin a_sel = 20'(valpha_ff); b_sel = 18'sd18919; end
         foc_pkg::OP_PB1: begin a_sel = -20'(valpha_ff); b_sel = 18'sd9459; end
         foc_pkg::OP_PB2: begin a_sel = 20'(vbeta_ff); b_sel = 18'sd16384; end
         foc_pkg::OP_PC1: begin a_sel = -20'(valpha_ff); b_sel = 18'sd9459; end
         foc_pkg::OP_PC2: begin a_sel = -20'(vbeta_ff); b_sel = 18'sd16384; end
         foc_pkg::OP_DA, foc_pkg::OP_DB, foc_pkg::OP_DC: begin
            a_sel = signed'({4'd0, u_ff});
            b_sel = 18'(PWM_PERIOD);
         end
         default: begin a_sel = 20'sd0; b_sel = 18'sd0; end
      endcase
      acc_keep = op_ff inside {foc_pkg::OP_BE2, foc_pkg::OP_ID2, foc_pkg::OP_IQ2,
                               foc_pkg::OP_VA2, foc_pkg::OP_VB2, foc_pkg::OP_PB2,
                               foc_pkg::OP_PC2};
   end

   // post-processing of the accumulated product
   always_comb begin
      rnd15     = (acc_ff + 40'sd16384) >>> 15;
      rnd12     = (acc_ff + 40'sd2048) >>> 12;
      rnd8      = (acc_ff + 40'sd128) >>> 8;
      integ_sel = (op_ff == foc_pkg::OP_DI || op_ff == foc_pkg::OP_DP) ?
                  40'(integ_d_ff) : 40'(integ_q_ff);
      integ_sum = integ_sel + rnd8;
      if (integ_sum > ILIM) begin
         integ_new = ILIM;
      end else if (integ_sum < -ILIM) begin
         integ_new = -ILIM;
      end else begin
         integ_new = integ_sum;
      end
      irnd  = (integ_sel + 40'sd128) >>> 8;
      v_sum = rnd12 + irnd;
      if (v_sum > OLIM) begin
         v_new = 16'(OLIM);
      end else if (v_sum < -OLIM) begin
         v_new = 16'(-OLIM);
      end else begin
         v_new = v_sum[15:0];
      end
      u_sum = 40'sd16384 + rnd15;
      if (u_sum < 40'sd0) begin
         u_new = 16'd0;
      end else if (u_sum > 40'sd32768) begin
         u_new = 16'd32768;
      end else begin
         u_new = u_sum[15:0];
      end
   end

   always_comb begin
      partial = b_sh_ff[0] ? a_sh_ff : 40'sd0;
      cor_req.start = (state_ff == ST_POST && op_ff == foc_pkg::OP_EL) ||
                      (state_ff == ST_COR1 && cor_rsp.done);
      cor_req.k     = (state_ff == ST_POST) ? {1'b0, acc_ff[9:0]} :
                      11'd1024 - {1'b0, elec_ff[9:0]};
      case (elec_ff[11:10])
         2'd0:    begin s_in = signed'(p_ff);  c_in = signed'(cor_rsp.value);  end
         2'd1:    begin s_in = signed'(cor_rsp.value); c_in = -signed'(p_ff); end
         2'd2:    begin s_in = -signed'(p_ff); c_in = -signed'(cor_rsp.value); end
         default: begin s_in = -signed'(cor_rsp.value); c_in = signed'(p_ff); end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         ia_off_ff <= 12'd2048;
         ib_off_ff <= 12'd2048;
         zero_ff   <= 12'd839;
         rev_ff    <= 1'b0;
         id_tgt_ff <= 16'sd0;
         iq_tgt_ff <= 16'sd0;
         kp_ff     <= 16'd4096;
         ki_ff     <= 16'd655;
      end else if (csr_we) begin
         case (csr_addr)
            foc_pkg::CSR_IA_OFFSET:   ia_off_ff <= csr_wdata[11:0];
            foc_pkg::CSR_IB_OFFSET:   ib_off_ff <= csr_wdata[11:0];
            foc_pkg::CSR_ANGLE_ZERO:  zero_ff   <= csr_wdata[11:0];
            foc_pkg::CSR_REVERSE_DIR: rev_ff    <= csr_wdata[0];
            foc_pkg::CSR_ID_TARGET:   id_tgt_ff <= signed'(csr_wdata);
            foc_pkg::CSR_IQ_TARGET:   iq_tgt_ff <= signed'(csr_wdata);
            foc_pkg::CSR_PI_KP:       kp_ff     <= csr_wdata;
            foc_pkg::CSR_PI_KI_DT:    ki_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer and control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= foc_pkg::OP_SA;
         cnt_ff       <= 5'd0;
         rsp_valid_ff <= 1'b0;
         integ_d_ff   <= 24'sd0;
         integ_q_ff   <= 24'sd0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  op_ff    <= foc_pkg::OP_SA;
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               cnt_ff   <= 5'd0;
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(MUL_BITS - 1)) begin
                  state_ff <= ST_POST;
               end
            end
            ST_POST: begin
               if (op_ff == foc_pkg::OP_DI) begin
                  integ_d_ff <= 24'(integ_new);
               end
               if (op_ff == foc_pkg::OP_QI) begin
                  integ_q_ff <= 24'(integ_new);
               end
               if (op_ff == foc_pkg::OP_EL) begin
                  state_ff <= ST_COR1;
               end else if (op_ff == foc_pkg::OP_DC) begin
                  state_ff <= ST_OUT;
               end else begin
                  op_ff    <= foc_pkg::op_type'(op_ff + 5'd1);
                  state_ff <= ST_LOAD;
               end
            end
            ST_COR1: begin
               if (cor_rsp.done) begin
                  state_ff <= ST_COR2;
               end
            end
            ST_COR2: begin
               if (cor_rsp.done) begin
                  op_ff    <= foc_pkg::OP_BE1;
                  state_ff <= ST_LOAD;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_tvalid) begin
         adc_a_ff <= req_tdata[11:0];
         adc_b_ff <= req_tdata[23:12];
         raw_ff   <= req_tdata[35:24];
      end
      if (state_ff == ST_LOAD) begin
         a_sh_ff <= 40'(a_sel);
         b_sh_ff <= b_sel;
         if (!acc_keep) begin
            acc_ff <= 40'sd0;
         end
      end
      if (state_ff == ST_MUL) begin
         if (cnt_ff == 5'(MUL_BITS - 1)) begin
            acc_ff <= acc_ff - partial;
         end else begin
            acc_ff <= acc_ff + partial;
         end
         a_sh_ff <= a_sh_ff <<< 1;
         b_sh_ff <= b_sh_ff >>> 1;
      end
      if (state_ff == ST_COR1 && cor_rsp.done) begin
         p_ff <= cor_rsp.value;
      end
      if (state_ff == ST_COR2 && cor_rsp.done) begin
         sin_ff <= s_in;
         cos_ff <= c_in;
      end
      if (state_ff == ST_POST) begin
         case (op_ff)
            foc_pkg::OP_SA:  ia_ff     <= sat16(acc_ff);
            foc_pkg::OP_SB:  ib_ff     <= sat16(acc_ff);
            foc_pkg::OP_EL:  elec_ff   <= acc_ff[11:0];
            foc_pkg::OP_BE2: beta_ff   <= rnd15[17:0];
            foc_pkg::OP_ID2: id_ff     <= sat16(rnd15);
            foc_pkg::OP_IQ2: iq_ff     <= sat16(rnd15);
            foc_pkg::OP_DP:  vd_ff     <= v_new;
            foc_pkg::OP_QP:  vq_ff     <= v_new;
            foc_pkg::OP_VA2: valpha_ff <= rnd15[17:0];
            foc_pkg::OP_VB2: vbeta_ff  <= rnd15[17:0];
            foc_pkg::OP_PA, foc_pkg::OP_PB2, foc_pkg::OP_PC2: u_ff <= u_new;
            foc_pkg::OP_DA:  duty_a_ff <= acc_ff[27:15];
            foc_pkg::OP_DB:  duty_b_ff <= acc_ff[27:15];
            default: ;
         endcase
      end
      if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= {5'd0, elec_ff, iq_ff, id_ff, acc_ff[27:15], duty_b_ff,
                         duty_a_ff};
      end
   end

endmodule
`default_nettype wire

/* rtl/foc_cordic.sv */
`default_nettype none
module foc_cordic (
   input  wire                   clock,
   input  wire                   reset,
   input  wire foc_pkg::cor_req_type req,
   output foc_pkg::cor_rsp_type  rsp
);

   logic               busy_ff;
   logic [3:0]         it_ff;
   logic signed [17:0] x_ff, y_ff, z_ff;
   logic signed [17:0] x_in, y_in, z_in;
   logic signed [17:0] dx, dy, step;
   logic [10:0]        k_ff;
   logic               done_ff;
   logic [15:0]        res_ff, res_in;

   always_comb begin
      dx   = y_ff >>> it_ff;
      dy   = x_ff >>> it_ff;
      step = signed'({4'b0000, foc_pkg::atan_step(it_ff)});
      if (!z_ff[17]) begin
         x_in = x_ff - dx;
         y_in = y_ff + dy;
         z_in = z_ff - step;
      end else begin
         x_in = x_ff + dx;
         y_in = y_ff - dy;
         z_in = z_ff + step;
      end
      if (k_ff == 11'd0) begin
         res_in = 16'd0;
      end else if (k_ff == 11'd1024) begin
         res_in = 16'd32767;
      end else if (y_in[17]) begin
         res_in = 16'd0;
      end else if (y_in > 18'sd32767) begin
         res_in = 16'd32767;
      end else begin
         res_in = y_in[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && it_ff == 4'd15) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         it_ff <= 4'd0;
         x_ff  <= foc_pkg::CORDIC_X0;
         y_ff  <= 18'sd0;
         z_ff  <= signed'({3'b000, req.k, 4'b0000});
         k_ff  <= req.k;
      end else if (busy_ff) begin
         it_ff <= it_ff + 4'd1;
         x_ff  <= x_in;
         y_ff  <= y_in;
         z_ff  <= z_in;
         if (it_ff == 4'd15) begin
            res_ff <= res_in;
         end
      end
   end

   assign rsp.done  = done_ff;
   assign rsp.value = res_ff;

endmodule
`default_nettype wire
